>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked during reset too
`define ASSERT_NXT_ALL(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/utf8e_pkg.sv
// types and constants of the utf-32 to utf-8 encoder
package utf8e_pkg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_NO_SPACE = 2'd2,
        ST_TERM     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_VALIDATE   = 2'd0,
        CFG_COUNT_ONLY = 2'd1,
        CFG_ZERO_TERM  = 2'd2,
        CFG_OUT_CAP    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        validate;
        logic        count_only;
        logic        zero_terminates;
        logic [31:0] out_capacity;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        validate:        1'b1,
        count_only:      1'b0,
        zero_terminates: 1'b0,
        out_capacity:    32'hFFFF_FFFF
    };

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [2:0] nbytes;
        logic       bad;
    } t_enc;

    typedef struct packed {
        logic [7:0]  byte_0;
        logic [7:0]  byte_1;
        logic [7:0]  byte_2;
        logic [7:0]  byte_3;
        logic [2:0]  byte_count;
        t_status     status;
        logic [2:0]  shortfall;
        logic [31:0] total_bytes;
        logic        done_res;
    } t_res;

    localparam logic [15:0] SURR_BASE    = 16'hD800;
    localparam logic [15:0] NONCHAR_LO   = 16'hFDD0;
    localparam logic [15:0] NONCHAR_HI   = 16'hFDEF;
    localparam logic [15:0] RESERVED_LOW = 16'hFFFE;
    localparam logic [31:0] CP_LIMIT     = 32'h0011_0000;
    localparam logic [7:0]  LEAD2        = 8'hC0;
    localparam logic [7:0]  LEAD3        = 8'hE0;
    localparam logic [7:0]  LEAD4        = 8'hF0;
    localparam logic [7:0]  CONT_MARK    = 8'h80;
    localparam logic [5:0]  CONT_MASK    = 6'h3F;

endpackage

>>> hw/rtl/utf8e_ifs.sv
// channel interfaces: configuration writes, input words, encoded results
interface utf8e_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface utf8e_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] code_point;
    logic        restart;
    logic        final_req;

    modport source (output valid, output code_point, output restart, output final_req,
                    input ready);
    modport sink   (input valid, input code_point, input restart, input final_req,
                    output ready);
endinterface

interface utf8e_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_0;
    logic [7:0]  byte_1;
    logic [7:0]  byte_2;
    logic [7:0]  byte_3;
    logic [2:0]  byte_count;
    logic [1:0]  status;
    logic [2:0]  shortfall;
    logic [31:0] total_bytes;
    logic        done_res;

    modport source (output valid, output byte_0, output byte_1, output byte_2,
                    output byte_3, output byte_count, output status, output shortfall,
                    output total_bytes, output done_res, input ready);
    modport sink   (input valid, input byte_0, input byte_1, input byte_2,
                    input byte_3, input byte_count, input status, input shortfall,
                    input total_bytes, input done_res, output ready);
endinterface

>>> hw/rtl/utf32_to_utf8_encoder.sv
// utf-32 to utf-8 encoder top level
// Takes one UTF-32 word per input beat and returns one result beat holding its
// UTF-8 bytes (up to four), the byte count, a status, a shortfall and the
// running byte total. A word passes an input register and then a result register
// before its result is offered; one word can be accepted every cycle unless the
// result side stalls. The running byte total and halt status are updated as each
// word moves into the result register. Validation, count-only, zero-terminated
// mode and the output buffer size are set through the configuration channel;
// the user must set them only while no word is in flight, as the block itself
// does not enforce it. After an invalid word, a full buffer or a terminator the
// block reports the same status on every word until one arrives with restart
// set.
module utf32_to_utf8_encoder import utf8e_pkg::*; #(
    parameter int unsigned TOTAL_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    utf8e_cfg_if.sink     i_cfg,
    utf8e_in_if.sink      i_in,
    utf8e_out_if.source   o_out
);

    localparam int unsigned CMP_W = (TOTAL_BITS > 32) ? TOTAL_BITS : 32;

    t_cfg                    cfg;
    t_enc                    enc;

    logic                    r_in_vld;
    logic [31:0]             r_code;
    logic                    r_restart;
    logic                    r_final;
    logic [TOTAL_BITS-1:0]   r_total;
    t_status                 r_halt;
    logic                    r_out_vld;
    t_res                    r_res;

    logic [TOTAL_BITS-1:0]   n_total;
    t_status                 n_halt;
    t_res                    n_res;

    logic                    adv;
    t_status                 halt_cur;
    logic [TOTAL_BITS-1:0]   tot_cur;
    logic [CMP_W:0]          tot_w;
    logic [CMP_W:0]          cap_w;
    logic [CMP_W:0]          sum_w;
    logic [CMP_W:0]          diff_w;
    logic [CMP_W-1:0]        tot_out;
    logic                    over;
    logic                    full;
    logic                    term;
    logic [2:0]              cnt;

    utf8e_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    utf8e_encode u_encode (
        .i_code_point (r_code),
        .i_validate   (cfg.validate),
        .o_enc        (enc)
    );

    assign adv        = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || adv;

    assign halt_cur = r_restart ? ST_OK : r_halt;
    assign tot_cur  = r_restart ? '0 : r_total;
    assign tot_w    = (CMP_W + 1)'(tot_cur);
    assign cap_w    = (CMP_W + 1)'(cfg.out_capacity);
    assign sum_w    = tot_w + (CMP_W + 1)'(enc.nbytes);
    assign diff_w   = sum_w - cap_w;
    assign over     = (sum_w > cap_w);
    assign full     = (tot_w >= cap_w);
    assign term     = cfg.zero_terminates && (r_code == '0);

    always_comb begin
        n_res = '0;
        cnt   = '0;
        priority if (halt_cur != ST_OK) begin
            n_res.status = halt_cur;
        end else if (enc.bad) begin
            n_res.status = ST_INVALID;
        end else if (!cfg.count_only && over) begin
            n_res.status    = ST_NO_SPACE;
            n_res.shortfall = full ? enc.nbytes : diff_w[2:0];
        end else begin
            cnt = (term && !cfg.count_only) ? 3'd0 : enc.nbytes;
            if (term) begin
                n_res.status = ST_TERM;
            end
        end
        n_total  = tot_cur + TOTAL_BITS'(cnt);
        n_halt   = n_res.status;
        tot_out  = CMP_W'(n_total);
        n_res.byte_count  = cnt;
        n_res.total_bytes = tot_out[31:0];
        n_res.done_res    = (n_res.status != ST_OK) || (!cfg.zero_terminates && r_final);
        if (!cfg.count_only && (cnt != 3'd0)) begin
            n_res.byte_0 = enc.b0;
            n_res.byte_1 = enc.b1;
            n_res.byte_2 = enc.b2;
            n_res.byte_3 = enc.b3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_total   <= '0;
            r_halt    <= ST_OK;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
                r_total   <= n_total;
                r_halt    <= n_halt;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_code    <= i_in.code_point;
            r_restart <= i_in.restart;
            r_final   <= i_in.final_req;
        end
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.byte_0      = r_res.byte_0;
    assign o_out.byte_1      = r_res.byte_1;
    assign o_out.byte_2      = r_res.byte_2;
    assign o_out.byte_3      = r_res.byte_3;
    assign o_out.byte_count  = r_res.byte_count;
    assign o_out.status      = r_res.status;
    assign o_out.shortfall   = r_res.shortfall;
    assign o_out.total_bytes = r_res.total_bytes;
    assign o_out.done_res    = r_res.done_res;

endmodule

>>> hw/rtl/utf8e_cfg.sv
// configuration register file of the encoder
module utf8e_cfg import utf8e_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    utf8e_cfg_if.sink  i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_VALIDATE:   n_cfg.validate        = i_cfg.data[0];
                CFG_COUNT_ONLY: n_cfg.count_only      = i_cfg.data[0];
                CFG_ZERO_TERM:  n_cfg.zero_terminates = i_cfg.data[0];
                CFG_OUT_CAP:    n_cfg.out_capacity    = i_cfg.data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> hw/rtl/utf8e_encode.sv
// utf-8 byte forming and code point checks for one word
module utf8e_encode import utf8e_pkg::*; (
    input  logic [31:0] i_code_point,
    input  logic        i_validate,
    output t_enc        o_enc
);

    logic lt_2b;
    logic lt_3b;
    logic lt_4b;
    logic surrogate;
    logic nonchar;
    logic reserved;

    assign lt_2b     = (i_code_point[31:7] == '0);
    assign lt_3b     = (i_code_point[31:11] == '0);
    assign lt_4b     = (i_code_point[31:16] == '0);
    assign surrogate = (i_code_point[15:11] == SURR_BASE[15:11]);
    assign nonchar   = (i_code_point[15:0] >= NONCHAR_LO) && (i_code_point[15:0] <= NONCHAR_HI);
    assign reserved  = (i_code_point[15:1] == RESERVED_LOW[15:1]);

    always_comb begin
        o_enc = '0;
        priority if (lt_2b) begin
            o_enc.nbytes = 3'd1;
            o_enc.b0     = i_code_point[7:0];
        end else if (lt_3b) begin
            o_enc.nbytes = 3'd2;
            o_enc.b0     = LEAD2 | {3'b000, i_code_point[10:6]};
            o_enc.b1     = CONT_MARK | {2'b00, i_code_point[5:0] & CONT_MASK};
        end else if (lt_4b) begin
            o_enc.nbytes = 3'd3;
            o_enc.bad    = i_validate && (surrogate || nonchar || reserved);
            o_enc.b0     = LEAD3 | {4'b0000, i_code_point[15:12]};
            o_enc.b1     = CONT_MARK | {2'b00, i_code_point[11:6] & CONT_MASK};
            o_enc.b2     = CONT_MARK | {2'b00, i_code_point[5:0] & CONT_MASK};
        end else begin
            o_enc.nbytes = 3'd4;
            o_enc.bad    = i_validate && ((i_code_point >= CP_LIMIT) || reserved);
            o_enc.b0     = LEAD4 | {5'b00000, i_code_point[20:18]};
            o_enc.b1     = CONT_MARK | {2'b00, i_code_point[17:12] & CONT_MASK};
            o_enc.b2     = CONT_MARK | {2'b00, i_code_point[11:6] & CONT_MASK};
            o_enc.b3     = CONT_MARK | {2'b00, i_code_point[5:0] & CONT_MASK};
        end
    end

endmodule

>>> hw/rtl/utf8e_checker.sv
// port-level checks on the encoder result channel, bound to the top level
`include "assert_macros.svh"

module utf8e_checker import utf8e_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_byte_count,
    input logic [1:0] i_status,
    input logic [2:0] i_shortfall,
    input logic       i_done_res
);

    // result valid held while stalled
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // no-space result writes nothing and its shortfall stays within one word
    `ASSERT_IMP(a_no_space, i_clk, i_rst_n, i_out_valid && (i_status == ST_NO_SPACE), (i_byte_count == 3'd0) && (i_shortfall <= 3'd4))

    // any halting status ends the stream
    `ASSERT_IMP(a_halt_done, i_clk, i_rst_n, i_out_valid && (i_status != ST_OK), i_done_res)

    // reset empties the result register
    `ASSERT_NXT_ALL(a_rst_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind utf32_to_utf8_encoder utf8e_checker u_utf8e_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_byte_count (o_out.byte_count),
    .i_status     (o_out.status),
    .i_shortfall  (o_out.shortfall),
    .i_done_res   (o_out.done_res)
);

>>> tb/sv/utf32_to_utf8_encoder_tb.sv
// self-checking testbench for the utf-32 to utf-8 encoder
module utf32_to_utf8_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import utf8e_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 16;
    localparam int LONG_HOLD   = 80;

    class utf8_encoding_board;
        t_cfg        regs = CFG_RESET;
        logic [31:0] byte_total = '0;
        t_status     halt_cause = ST_OK;
        t_res        awaited_encodings[$];
        int          mismatches = 0;
        int          words = 0;
        int          results = 0;
        int          settings = 0;
        int          seen_status[4] = '{0, 0, 0, 0};

        function void set_reg(t_cfg_idx idx, logic [31:0] value);
            case (idx)
                CFG_VALIDATE:   regs.validate        = value[0];
                CFG_COUNT_ONLY: regs.count_only      = value[0];
                CFG_ZERO_TERM:  regs.zero_terminates = value[0];
                CFG_OUT_CAP:    regs.out_capacity    = value;
                default: ;
            endcase
        endfunction

        function void note_word(logic [31:0] cp, logic rs, logic fr);
            t_res        r;
            logic [7:0]  b0, b1, b2, b3;
            logic [2:0]  need;
            logic [31:0] room;
            logic        term, bad;
            r = '0;
            {b0, b1, b2, b3} = '0;
            need = '0;
            term = 1'b0;
            bad = 1'b0;
            words++;
            if (rs) begin
                byte_total = '0;
                halt_cause = ST_OK;
            end
            if (halt_cause != ST_OK) begin
                r.status = halt_cause;
                r.done_res = 1'b1;
            end else begin
                if (cp < 32'h80) begin
                    need = 3'd1;
                    b0 = cp[7:0];
                    term = regs.zero_terminates && (cp == '0);
                end else if (cp < 32'h800) begin
                    need = 3'd2;
                    b0 = LEAD2 | {3'b0, cp[10:6]};
                    b1 = CONT_MARK | {2'b0, cp[5:0]};
                end else if (cp < 32'h1_0000) begin
                    bad = regs.validate && ((cp[15:11] == SURR_BASE[15:11]) ||
                          (cp[15:0] >= NONCHAR_LO && cp[15:0] <= NONCHAR_HI) ||
                          (cp[15:1] == RESERVED_LOW[15:1]));
                    need = 3'd3;
                    b0 = LEAD3 | {4'b0, cp[15:12]};
                    b1 = CONT_MARK | {2'b0, cp[11:6]};
                    b2 = CONT_MARK | {2'b0, cp[5:0]};
                end else begin
                    bad = regs.validate && (cp >= CP_LIMIT || cp[15:1] == RESERVED_LOW[15:1]);
                    need = 3'd4;
                    b0 = LEAD4 | {5'b0, cp[20:18]};
                    b1 = CONT_MARK | {2'b0, cp[17:12]};
                    b2 = CONT_MARK | {2'b0, cp[11:6]};
                    b3 = CONT_MARK | {2'b0, cp[5:0]};
                end

                if (bad) begin
                    r.status = ST_INVALID;
                end else if (!regs.count_only) begin
                    room = (regs.out_capacity > byte_total) ? regs.out_capacity - byte_total : '0;
                    if (need > room) begin
                        r.status = ST_NO_SPACE;
                        r.shortfall = need - room[2:0];
                    end else if (term) begin
                        r.status = ST_TERM;
                    end else begin
                        r.byte_count = need;
                    end
                end else begin
                    r.byte_count = need;
                    if (term) r.status = ST_TERM;
                end

                if (r.status != ST_OK) begin
                    halt_cause = r.status;
                    r.done_res = 1'b1;
                end else if (!regs.zero_terminates && fr) begin
                    r.done_res = 1'b1;
                end
                byte_total = byte_total + r.byte_count;
                if (!regs.count_only && r.byte_count != '0)
                    {r.byte_0, r.byte_1, r.byte_2, r.byte_3} = {b0, b1, b2, b3};
            end
            r.total_bytes = byte_total;
            awaited_encodings.push_back(r);
        endfunction

        function void field_check(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 100)
                    $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            results++;
            if (awaited_encodings.size() == 0) begin
                mismatches++;
                if (mismatches <= 100)
                    $display("%0t ns: result beat with no word outstanding, expected none actual %h",
                             $time, got);
                return;
            end
            want = awaited_encodings.pop_front();
            seen_status[want.status]++;
            field_check("byte_0", want.byte_0, got.byte_0);
            field_check("byte_1", want.byte_1, got.byte_1);
            field_check("byte_2", want.byte_2, got.byte_2);
            field_check("byte_3", want.byte_3, got.byte_3);
            field_check("byte_count", want.byte_count, got.byte_count);
            field_check("status", want.status, got.status);
            field_check("shortfall", want.shortfall, got.shortfall);
            field_check("total_bytes", want.total_bytes, got.total_bytes);
            field_check("done_res", want.done_res, got.done_res);
        endfunction

        function int outstanding();
            return awaited_encodings.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    utf8e_cfg_if cfg_ch ();
    utf8e_in_if  in_ch ();
    utf8e_out_if out_ch ();

    utf8_encoding_board board = new;
    bit calm = 1'b0;
    int hold_len = 0;
    int quiet_cycles = 0;

    utf32_to_utf8_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    function automatic int draw_gap();
        if (calm) return 0;
        return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 17) : 0;
    endfunction

    function automatic logic [31:0] draw_code_point();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) return $urandom_range(1, 32'h7F);
        if (pick < 50) return $urandom_range(32'h80, 32'h7FF);
        if (pick < 70) return $urandom_range(32'h800, 32'hFFFF);
        if (pick < 90) return $urandom_range(32'h1_0000, 32'h10_FFFF);
        if (pick < 93) return '0;
        if (pick < 98) begin
            case ($urandom_range(0, 4))
                0: return {16'h0, SURR_BASE} + $urandom_range(0, 32'h7FF);
                1: return {16'h0, NONCHAR_LO} + $urandom_range(0, 31);
                2: return (32'($urandom_range(0, 16)) << 16) | {16'h0, RESERVED_LOW} |
                          32'($urandom_range(0, 1));
                3: return CP_LIMIT + $urandom_range(0, 255);
                default: return $urandom_range(32'hFFFF_FFFF, CP_LIMIT);
            endcase
        end
        return $urandom();
    endfunction

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_word(logic [31:0] cp, logic rs, logic fr);
        int gap;
        gap = draw_gap();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.code_point <= cp;
        in_ch.restart    <= rs;
        in_ch.final_req  <= fr;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        board.note_word(cp, rs, fr);
        @(negedge i_clk);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (board.outstanding() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apply_settings(logic v, logic co, logic zt, logic [31:0] cap);
        t_cfg_idx    order [4];
        logic [31:0] vals [4];
        order = '{CFG_VALIDATE, CFG_COUNT_ONLY, CFG_ZERO_TERM, CFG_OUT_CAP};
        vals  = '{{31'b0, v}, {31'b0, co}, {31'b0, zt}, cap};
        settle();
        for (int i = 0; i < 4; i++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= order[i];
            cfg_ch.data  <= vals[i];
            @(posedge i_clk);
            while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
            board.set_reg(order[i], vals[i]);
            @(negedge i_clk);
        end
        cfg_ch.valid <= 1'b0;
        board.settings++;
    endtask

    // streams mostly open with a restart and mostly close with a final or zero word
    task automatic run_streams(int n_words);
        int          left, len;
        logic [31:0] cp;
        logic        rs, fr;
        left = n_words;
        while (left > 0) begin
            len = $urandom_range(1, 40);
            if (len > left) len = left;
            for (int i = 0; i < len; i++) begin
                cp = draw_code_point();
                rs = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
                fr = (i == len - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 29) == 0);
                if (board.regs.zero_terminates && i == len - 1 && $urandom_range(0, 1) != 0)
                    cp = '0;
                send_word(cp, rs, fr);
                if ($urandom_range(0, 199) == 0) settle();
            end
            left -= len;
        end
    endtask

    initial begin : result_sink
        int   gap;
        t_res got;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = draw_gap();
            if (hold_len != 0) begin
                gap = hold_len;
                hold_len = 0;
            end
            if (gap != 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (out_ch.valid !== 1'b1) @(posedge i_clk);
            got.byte_0      = out_ch.byte_0;
            got.byte_1      = out_ch.byte_1;
            got.byte_2      = out_ch.byte_2;
            got.byte_3      = out_ch.byte_3;
            got.byte_count  = out_ch.byte_count;
            got.status      = t_status'(out_ch.status);
            got.shortfall   = out_ch.shortfall;
            got.total_bytes = out_ch.total_bytes;
            got.done_res    = out_ch.done_res;
            board.check_result(got);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready) ||
            (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t ns: no beat for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, board.outstanding());
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [31:0] cap;
        i_rst_n          = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_VALIDATE;
        cfg_ch.data      = '0;
        in_ch.valid      = 1'b0;
        in_ch.code_point = '0;
        in_ch.restart    = 1'b0;
        in_ch.final_req  = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // length boundaries, then each rejected class, each cleared by a restart
        apply_settings(1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_word(32'h0, 1'b0, 1'b0);
        send_word(32'h7F, 1'b0, 1'b0);
        send_word(32'h80, 1'b0, 1'b0);
        send_word(32'h7FF, 1'b0, 1'b0);
        send_word(32'h800, 1'b0, 1'b0);
        send_word(32'hFFFD, 1'b0, 1'b0);
        send_word(32'h1_0000, 1'b0, 1'b0);
        send_word(32'h10_FFFF, 1'b0, 1'b1);
        send_word(32'hD800, 1'b0, 1'b0);
        send_word(32'h41, 1'b0, 1'b0);
        send_word(32'hFDD0, 1'b1, 1'b0);
        send_word(32'hFDEF, 1'b1, 1'b0);
        send_word(32'hFFFE, 1'b1, 1'b0);
        send_word(32'h1_FFFF, 1'b1, 1'b0);
        send_word(32'h11_0000, 1'b1, 1'b0);
        send_word(32'hE000, 1'b1, 1'b1);
        // no validation: surrogates pass, high bits dropped from the lead byte
        apply_settings(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_word(32'hDFFF, 1'b1, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_word(32'h11_0000, 1'b0, 1'b1);
        // tight buffer with zero termination
        apply_settings(1'b1, 1'b0, 1'b1, 32'd5);
        send_word(32'h1_0000, 1'b1, 1'b0);
        send_word(32'h0, 1'b0, 1'b1);
        send_word(32'h1_0000, 1'b1, 1'b0);
        send_word(32'h800, 1'b0, 1'b0);
        // count only, no buffer limit, terminator counted
        apply_settings(1'b1, 1'b1, 1'b1, 32'h0);
        send_word(32'h41, 1'b1, 1'b0);
        send_word(32'h10_FFFF, 1'b0, 1'b0);
        send_word(32'h0, 1'b0, 1'b0);

        for (int phase = 0; phase < PHASES; phase++) begin
            case ($urandom_range(0, 4))
                0: cap = '0;
                1: cap = 32'hFFFF_FFFF;
                2: cap = $urandom_range(1, 8);
                3: cap = $urandom_range(9, 400);
                default: cap = $urandom();
            endcase
            if (phase == 0) cap = '0;
            if (phase == 1) cap = 32'hFFFF_FFFF;
            apply_settings($urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0,
                           $urandom_range(0, 2) == 0, cap);
            calm = (phase % 5 == 2) || (phase == 3) || (phase == 11);
            // receiver stalls long enough for the pipeline to back up
            if (phase == 3 || phase == 11) hold_len = LONG_HOLD;
            run_streams($urandom_range(80, 140));
            calm = 1'b0;
        end

        settle();
        $display("covered %0d words over %0d register settings, %0d results compared",
                 board.words, board.settings, board.results);
        $display("result mix: ok %0d, invalid %0d, no space %0d, terminator %0d",
                 board.seen_status[ST_OK], board.seen_status[ST_INVALID],
                 board.seen_status[ST_NO_SPACE], board.seen_status[ST_TERM]);
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     board.mismatches, board.outstanding());
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
